### rtl/qsort_pkg.sv
package qsort_pkg;

    // element width, fixed by the data format
    localparam int DATA_W    = 32;
    // default store depth
    localparam int DEPTH_DEF = 64;

    // sequencer states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_PIV_RD,
        ST_PIV_LD,
        ST_UP_STEP,
        ST_UP_CHK,
        ST_DN_STEP,
        ST_DN_CHK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_DECIDE,
        ST_POP,
        ST_POP_LD,
        ST_EMIT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } ctrl_state_t;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_PIV_RD,
        OP_PIV_LD,
        OP_UP_STEP,
        OP_UP_DONE,
        OP_DN_STEP,
        OP_DN_DONE,
        OP_SWAP_A,
        OP_SWAP_B,
        OP_FIN_A,
        OP_FIN_B,
        OP_DECIDE,
        OP_POP_RD,
        OP_POP_LD,
        OP_EMIT_RD,
        OP_OUT_LD,
        OP_OUT_NEXT,
        OP_FINISH
    } dp_op_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic cnt_gt1;     // more than one element held
        logic up_scan;     // upward scan continues
        logic dn_scan;     // downward scan continues
        logic up_lt_down;  // indices have not crossed
        logic more;        // smaller subrange still needs splitting
        logic sp_zero;     // range stack empty
        logic stk_lt;      // popped range has lo below hi
        logic emit_last;   // current output index is the last element
    } dp_status_t;

endpackage

### rtl/quicksort_engine.sv
// quicksort_engine: loads signed 32-bit values, one beat per cycle, into an
// on-chip element store until a beat with final_item set, then sorts the set
// ascending in place (first element of each range as pivot, two-index
// partition, pending ranges on a small range stack) and streams the sorted
// values out, one beat per element, with run_end on the last one. Values past
// DEPTH are dropped and every output beat of that set shows overflowed. The
// input stalls from the final beat until the last sorted beat is taken.
// Sorting speed is set by the element memory, which has one write port and
// one registered read port: each partition reads the elements it compares
// one at a time, and each swap costs two writes and the restart of both
// scans. An already sorted set is the slowest case. No clearing pass is
// needed after reset.
module quicksort_engine
#(
    parameter int DEPTH = qsort_pkg::DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [qsort_pkg::DATA_W-1:0]  sample_value,
    input  logic                                 final_item,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [qsort_pkg::DATA_W-1:0]  sorted_value,
    output logic                                 run_end,
    output logic                                 overflowed
);
    import qsort_pkg::*;

    // command and status between sequencer and datapath
    dp_op_t     op;
    dp_status_t st;

    // sequencer: load, partition, pop and emit phases
    qsort_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_item (final_item),
        .out_stall  (out_stall),
        .st         (st),
        .in_stall   (in_stall),
        .op         (op)
    );

    // datapath: element store, range stack, scan indices, output register
    qsort_datapath
    #(
        .DEPTH (DEPTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .sample_value (sample_value),
        .st           (st),
        .sorted_value (sorted_value),
        .run_end      (run_end),
        .overflowed   (overflowed),
        .out_valid    (out_valid)
    );

endmodule

### rtl/qsort_ctrl.sv
module qsort_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   final_item,
    input  logic                   out_stall,
    input  qsort_pkg::dp_status_t  st,
    output logic                   in_stall,
    output qsort_pkg::dp_op_t      op
);
    import qsort_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_stall   = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    op = OP_LOAD;
                    if (final_item)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                op         = OP_INIT;
                state_next = st.cnt_gt1 ? ST_PIV_RD : ST_EMIT_RD;
            end
            ST_PIV_RD:
            begin
                op         = OP_PIV_RD;
                state_next = ST_PIV_LD;
            end
            ST_PIV_LD:
            begin
                op         = OP_PIV_LD;
                state_next = ST_UP_STEP;
            end
            ST_UP_STEP:
            begin
                op         = OP_UP_STEP;
                state_next = ST_UP_CHK;
            end
            ST_UP_CHK:
            begin
                if (st.up_scan)
                begin
                    op = OP_UP_STEP;
                end
                else
                begin
                    op         = OP_UP_DONE;
                    state_next = ST_DN_STEP;
                end
            end
            ST_DN_STEP:
            begin
                op         = OP_DN_STEP;
                state_next = ST_DN_CHK;
            end
            ST_DN_CHK:
            begin
                if (st.dn_scan)
                begin
                    op = OP_DN_STEP;
                end
                else
                begin
                    op         = OP_DN_DONE;
                    state_next = st.up_lt_down ? ST_SWAP_A : ST_FIN_A;
                end
            end
            ST_SWAP_A:
            begin
                op         = OP_SWAP_A;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                op         = OP_SWAP_B;
                state_next = ST_UP_STEP;
            end
            ST_FIN_A:
            begin
                op         = OP_FIN_A;
                state_next = ST_FIN_B;
            end
            ST_FIN_B:
            begin
                op         = OP_FIN_B;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                op         = OP_DECIDE;
                state_next = st.more ? ST_PIV_RD : ST_POP;
            end
            ST_POP:
            begin
                if (st.sp_zero)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    op         = OP_POP_RD;
                    state_next = ST_POP_LD;
                end
            end
            ST_POP_LD:
            begin
                op         = OP_POP_LD;
                state_next = st.stk_lt ? ST_PIV_RD : ST_POP;
            end
            ST_EMIT_RD:
            begin
                op         = OP_EMIT_RD;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                op         = OP_OUT_LD;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (!out_stall)
                begin
                    if (st.emit_last)
                    begin
                        op         = OP_FINISH;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        op         = OP_OUT_NEXT;
                        state_next = ST_OUT_LD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### rtl/qsort_datapath.sv
module qsort_datapath
#(
    parameter int DEPTH = qsort_pkg::DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  qsort_pkg::dp_op_t                    op,
    input  logic signed [qsort_pkg::DATA_W-1:0]  sample_value,
    output qsort_pkg::dp_status_t                st,
    output logic signed [qsort_pkg::DATA_W-1:0]  sorted_value,
    output logic                                 run_end,
    output logic                                 overflowed,
    output logic                                 out_valid
);
    import qsort_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // storage
    logic signed [DATA_W-1:0] elem_mem [DEPTH];
    logic        [2*AW-1:0]   stk_mem  [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic        [2*AW-1:0]   stk_rd_reg;

    // control registers
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [AW-1:0]            lo_reg, lo_next;
    logic [AW-1:0]            hi_reg, hi_next;
    logic [AW-1:0]            up_reg, up_next;
    logic [AW-1:0]            down_reg, down_next;
    logic [AW-1:0]            k_reg, k_next;
    logic                     first_reg, first_next;
    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic signed [DATA_W-1:0] uval_reg, uval_next;
    logic signed [DATA_W-1:0] dval_reg, dval_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic                     run_end_reg, run_end_next;
    logic                     out_ovf_reg, out_ovf_next;

    // memory ports
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic signed [DATA_W-1:0] mem_wd;
    logic [AW-1:0]            mem_ra;
    logic                     stk_we;
    logic [AW-1:0]            stk_wa;
    logic [2*AW-1:0]          stk_wd;
    logic                     stk_re;
    logic [AW-1:0]            stk_ra;

    // derived values
    logic [CW-1:0] n_last_full;
    logic [AW-1:0] n_last;
    logic [CW-1:0] sp_m1;
    logic [AW-1:0] dn_addr;
    logic [AW-1:0] left_len;
    logic [AW-1:0] right_len;
    logic          left_ge;
    logic          left_big;
    logic          right_big;
    logic          can_push;

    assign n_last_full = count_reg - CW'(1);
    assign n_last      = n_last_full[AW-1:0];
    assign sp_m1       = sp_reg - CW'(1);
    assign dn_addr     = first_reg ? hi_reg : (down_reg - AW'(1));
    assign left_len    = down_reg - lo_reg;
    assign right_len   = hi_reg - down_reg;
    assign left_ge     = (left_len >= right_len);
    assign left_big    = (left_len > AW'(1));
    assign right_big   = (right_len > AW'(1));
    assign can_push    = (sp_reg < CW'(DEPTH));

    assign st.cnt_gt1    = (count_reg > CW'(1));
    assign st.up_scan    = (up_reg < hi_reg) && (rd_data_reg <= pivot_reg);
    assign st.dn_scan    = (rd_data_reg > pivot_reg);
    assign st.up_lt_down = (up_reg < down_reg);
    assign st.more       = left_ge ? right_big : left_big;
    assign st.sp_zero    = (sp_reg == '0);
    assign st.stk_lt     = (stk_rd_reg[2*AW-1:AW] < stk_rd_reg[AW-1:0]);
    assign st.emit_last  = (k_reg == n_last);

    assign sorted_value = out_data_reg;
    assign run_end      = run_end_reg;
    assign overflowed   = out_ovf_reg;
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        count_next     = count_reg;
        sp_next        = sp_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        pivot_next     = pivot_reg;
        uval_next      = uval_reg;
        dval_next      = dval_reg;
        out_data_next  = out_data_reg;
        run_end_next   = run_end_reg;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = '0;
        stk_we         = 1'b0;
        stk_wa         = sp_reg[AW-1:0];
        stk_wd         = '0;
        stk_re         = 1'b0;
        stk_ra         = sp_m1[AW-1:0];
        case (op)
            OP_LOAD:
            begin
                if (count_reg < CW'(DEPTH))
                begin
                    mem_we     = 1'b1;
                    mem_wa     = count_reg[AW-1:0];
                    mem_wd     = sample_value;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            OP_INIT:
            begin
                lo_next = '0;
                hi_next = n_last;
                k_next  = '0;
                sp_next = '0;
            end
            OP_PIV_RD:
            begin
                mem_ra = lo_reg;
            end
            OP_PIV_LD:
            begin
                pivot_next = rd_data_reg;
                up_next    = lo_reg;
                first_next = 1'b1;
            end
            OP_UP_STEP:
            begin
                up_next = up_reg + AW'(1);
                mem_ra  = up_reg + AW'(1);
            end
            OP_UP_DONE:
            begin
                uval_next = rd_data_reg;
            end
            OP_DN_STEP:
            begin
                down_next  = dn_addr;
                mem_ra     = dn_addr;
                first_next = 1'b0;
            end
            OP_DN_DONE:
            begin
                dval_next = rd_data_reg;
            end
            OP_SWAP_A:
            begin
                mem_we = 1'b1;
                mem_wa = up_reg;
                mem_wd = dval_reg;
            end
            OP_SWAP_B:
            begin
                mem_we = 1'b1;
                mem_wa = down_reg;
                mem_wd = uval_reg;
            end
            OP_FIN_A:
            begin
                mem_we = 1'b1;
                mem_wa = lo_reg;
                mem_wd = dval_reg;
            end
            OP_FIN_B:
            begin
                mem_we = 1'b1;
                mem_wa = down_reg;
                mem_wd = pivot_reg;
            end
            OP_DECIDE:
            begin
                // push the larger side, keep splitting the smaller one
                if (left_ge)
                begin
                    if (left_big && can_push)
                    begin
                        stk_we  = 1'b1;
                        stk_wd  = {lo_reg, down_reg - AW'(1)};
                        sp_next = sp_reg + CW'(1);
                    end
                    if (right_big)
                    begin
                        lo_next = down_reg + AW'(1);
                    end
                end
                else
                begin
                    if (right_big && can_push)
                    begin
                        stk_we  = 1'b1;
                        stk_wd  = {down_reg + AW'(1), hi_reg};
                        sp_next = sp_reg + CW'(1);
                    end
                    if (left_big)
                    begin
                        hi_next = down_reg - AW'(1);
                    end
                end
            end
            OP_POP_RD:
            begin
                stk_re  = 1'b1;
                sp_next = sp_m1;
            end
            OP_POP_LD:
            begin
                lo_next = stk_rd_reg[2*AW-1:AW];
                hi_next = stk_rd_reg[AW-1:0];
            end
            OP_EMIT_RD:
            begin
                mem_ra = k_reg;
            end
            OP_OUT_LD:
            begin
                out_data_next  = rd_data_reg;
                run_end_next   = (k_reg == n_last);
                out_ovf_next   = ovf_reg;
                out_valid_next = 1'b1;
            end
            OP_OUT_NEXT:
            begin
                k_next         = k_reg + AW'(1);
                mem_ra         = k_reg + AW'(1);
                out_valid_next = 1'b0;
            end
            OP_FINISH:
            begin
                out_valid_next = 1'b0;
                count_next     = '0;
                ovf_next       = 1'b0;
                sp_next        = '0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sp_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        up_reg       <= up_next;
        down_reg     <= down_next;
        k_reg        <= k_next;
        first_reg    <= first_next;
        pivot_reg    <= pivot_next;
        uval_reg     <= uval_next;
        dval_reg     <= dval_next;
        out_data_reg <= out_data_next;
        run_end_reg  <= run_end_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // element store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            elem_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= elem_mem[mem_ra];
    end

    // range stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

`ifndef NO_ASSERTIONS
    a_down_above_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DN_STEP && !first_reg) |-> (down_reg > lo_reg))
        else $error("downward scan would pass range start");

    a_swap_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_SWAP_A) |-> (up_reg < down_reg))
        else $error("swap issued with crossed indices");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_POP_RD) |-> (sp_reg != '0))
        else $error("pop from empty range stack");

    a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PIV_RD) |-> (lo_reg < hi_reg))
        else $error("partition started on a range shorter than two");
`endif

endmodule

### bench/quicksort_engine_tb.sv
`timescale 1ns / 100ps

module quicksort_engine_tb;

    import qsort_pkg::*;

    localparam int STORE_DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // one expected output beat
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } sorted_beat_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] sample_value;
    logic                     final_item;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     run_end;
    logic                     overflowed;

    // predicted set contents, mirrors what the block holds
    logic signed [DATA_W-1:0] held_values [STORE_DEPTH];
    int                       held_count;
    bit                       held_overflow;

    // sorted beats still to come out, oldest first
    sorted_beat_t             sorted_due [$];
    sorted_beat_t             due_beat;

    int  errors;
    int  cycle_count;
    int  beats_in;
    int  beats_checked;
    int  sets_closed;
    int  sets_over_depth;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_left;

    quicksort_engine uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .final_item   (final_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .run_end      (run_end),
        .overflowed   (overflowed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // runaway guard, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, sorted_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor: hoare-style partition with the first element as pivot,
    // upward scan bounded at the range end, explicit range stack
    // ---------------------------------------------------------------

    function automatic void swap_held(int a, int b);
        logic signed [DATA_W-1:0] t;
        t = held_values[a];
        held_values[a] = held_values[b];
        held_values[b] = t;
    endfunction

    function automatic int partition_span(int lo, int hi);
        logic signed [DATA_W-1:0] pivot;
        int up;
        int down;
        pivot = held_values[lo];
        up = lo;
        down = hi + 1;
        while (up < down)
        begin
            up++;
            while (up < hi && held_values[up] <= pivot)
                up++;
            down--;
            while (held_values[down] > pivot)
                down--;
            if (up < down)
                swap_held(up, down);
        end
        swap_held(lo, down);
        return down;
    endfunction

    function automatic void sort_held(int n);
        int lo_stack [$];
        int hi_stack [$];
        int lo;
        int hi;
        int p;
        int left;
        int right;
        if (n > 1)
        begin
            lo_stack.push_back(0);
            hi_stack.push_back(n - 1);
        end
        while (lo_stack.size() > 0)
        begin
            lo = lo_stack.pop_back();
            hi = hi_stack.pop_back();
            // larger side goes on the stack, smaller side is split at once
            while (lo < hi && hi < n)
            begin
                p = partition_span(lo, hi);
                left = p - lo;
                right = hi - p;
                if (left >= right)
                begin
                    if (left >= 2)
                    begin
                        lo_stack.push_back(lo);
                        hi_stack.push_back(p - 1);
                    end
                    if (right < 2)
                        break;
                    lo = p + 1;
                end
                else
                begin
                    if (right >= 2)
                    begin
                        lo_stack.push_back(p + 1);
                        hi_stack.push_back(hi);
                    end
                    if (left < 2)
                        break;
                    hi = p - 1;
                end
            end
        end
    endfunction

    // one accepted input beat: store or drop it, close the set on final
    function automatic void absorb_sample(logic signed [DATA_W-1:0] v, logic fin);
        sorted_beat_t b;
        if (held_count < STORE_DEPTH)
        begin
            held_values[held_count] = v;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (fin)
        begin
            sort_held(held_count);
            for (int k = 0; k < held_count; k++)
            begin
                b.value = held_values[k];
                b.last  = (k == held_count - 1);
                b.ovf   = held_overflow;
                sorted_due.push_back(b);
            end
            sets_closed++;
            if (held_overflow)
                sets_over_depth++;
            held_count = 0;
            held_overflow = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------
    // input side: offer one beat, hold it until accepted
    // ---------------------------------------------------------------

    task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        final_item   <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_in++;
        absorb_sample(v, fin);
        @(negedge clk);
    endtask

    // drop valid and hold off until every sorted beat has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return ($urandom_range(1)) ? MOST_NEG : MOST_POS;
            1:       return ($urandom_range(1)) ? 32'sd0 : -32'sd1;
            2, 3:    return $signed($urandom_range(15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // output side: random stall plus a counted long hold-off
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // every taken output beat is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (sorted_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got value %0d end %b ovf %b",
                         $time, sorted_value, run_end, overflowed);
                errors++;
            end
            else
            begin
                due_beat = sorted_due.pop_front();
                if (sorted_value !== $signed(due_beat.value))
                begin
                    $display("%0t: sorted_value expected %0d, got %0d",
                             $time, $signed(due_beat.value), sorted_value);
                    errors++;
                end
                if (run_end !== due_beat.last)
                begin
                    $display("%0t: run_end expected %b, got %b",
                             $time, due_beat.last, run_end);
                    errors++;
                end
                if (overflowed !== due_beat.ovf)
                begin
                    $display("%0t: overflowed expected %b, got %b",
                             $time, due_beat.ovf, overflowed);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // one-element set and a pair of equal values
    task automatic test_tiny_sets();
        send_beat(MOST_POS, 1'b1);
        send_beat(-32'sd5, 1'b0);
        send_beat(-32'sd5, 1'b1);
    endtask

    // extremes of the value range, with duplicates of both ends
    task automatic test_extremes();
        send_beat(MOST_POS, 1'b0);
        send_beat(MOST_NEG, 1'b0);
        send_beat(32'sd0, 1'b0);
        send_beat(-32'sd1, 1'b0);
        send_beat(32'sd1, 1'b0);
        send_beat(MOST_NEG, 1'b0);
        send_beat(MOST_POS, 1'b1);
    endtask

    // ascending and descending input order
    task automatic test_presorted();
        for (int i = 0; i < 8; i++)
            send_beat(i * 1000 - 3500, i == 7);
        for (int i = 0; i < 8; i++)
            send_beat(4 - i, i == 7);
    endtask

    // exactly full store, worst-case ascending order, then a set past the
    // depth whose final beat is itself dropped but still closes the set
    task automatic test_store_full();
        for (int i = 0; i < STORE_DEPTH; i++)
            send_beat(i - 20, i == STORE_DEPTH - 1);
        for (int i = 0; i < STORE_DEPTH + 6; i++)
            send_beat(pick_sample(), i == STORE_DEPTH + 5);
    endtask

    // receiver holds off while the sender keeps offering, so the block
    // fills up and stalls its input; then the sender pauses for a drain
    task automatic test_backpressure();
        @(posedge clk);
        hold_left = 1000;
        @(negedge clk);
        for (int i = 0; i < 20; i++)
            send_beat(pick_sample(), i == 19);
        for (int i = 0; i < 10; i++)
            send_beat(pick_sample(), i == 9);
        wait_drained();
        for (int i = 0; i < 5; i++)
            send_beat(pick_sample(), i == 4);
        wait_drained();
    endtask

    // random sets, mostly small, some near full, a few past the depth
    task automatic test_random_sets(input int idle_pct, input int stall_pct, input int beats);
        int sent;
        int set_size;
        int r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < beats)
        begin
            r = $urandom_range(99);
            if (r < 80)
                set_size = $urandom_range(12, 1);
            else if (r < 96)
                set_size = $urandom_range(STORE_DEPTH, 13);
            else
                set_size = $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 1);
            for (int i = 0; i < set_size; i++)
                send_beat(pick_sample(), i == set_size - 1);
            sent += set_size;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_value   = '0;
        final_item     = 1'b0;
        out_stall      = 1'b0;
        held_count     = 0;
        held_overflow  = 1'b0;
        errors         = 0;
        cycle_count    = 0;
        beats_in       = 0;
        beats_checked  = 0;
        sets_closed    = 0;
        sets_over_depth = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_tiny_sets();
        test_extremes();
        test_presorted();
        test_store_full();
        test_backpressure();

        test_random_sets(0, 0, 75);
        test_random_sets(54, 0, 75);
        test_random_sets(0, 54, 75);
        test_random_sets(16, 16, 75);

        // last set out, then a margin for any stray beat
        wait_drained();
        repeat (100) @(posedge clk);

        $display("run covered %0d input beats in %0d sets (%0d past the store depth)",
                 beats_in, sets_closed, sets_over_depth);
        $display("%0d sorted beats checked in %0d cycles", beats_checked, cycle_count);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/qsort_pkg.sv
rtl/qsort_ctrl.sv
rtl/qsort_datapath.sv
rtl/quicksort_engine.sv
bench/quicksort_engine_tb.sv
